// ===== rtl/core/gpg_pkg.sv =====
// Shared constants for the gyroid potential and gradient pipeline.
`default_nettype none
package gpg_pkg;
  localparam int COORD_BITS = 16;
  localparam int LATENCY = 13;
  localparam int LANES = 6;
  localparam int PEN_W = 19;
  localparam int GRAD_W = 22;

  localparam logic signed [31:0] A1 = 32'sd1686629713;
  localparam logic signed [31:0] A3 = -32'sd693598671;
  localparam logic signed [31:0] A5 = 32'sd85569305;
  localparam logic signed [31:0] A7 = -32'sd5026995;
  localparam logic signed [31:0] A9 = 32'sd172271;
  localparam logic signed [28:0] FOUR_PI_Q24 = 29'sd210828715;
  localparam logic [14:0] ONE_Q14 = 15'd16384;
endpackage
`default_nettype wire

// ===== rtl/core/gyroid_potential_gradient.sv =====
// Gyroid level penalty and gradient, thirteen-stage pipeline.
//
//  channel | ports                              | transfer
//  input   | start, busy, in_coord_x/y/z        | start high, busy low
//  result  | out_valid, out_penalty, out_grad_* | out_valid high, one cycle
//  config  | cfg_we, cfg_wdata                  | cfg_we high, out of reset
//
// One point enters per cycle; its result is taken from the stage 13 register.
// Stages: seven sine stages (fold, t^2, four Horner steps, final multiply)
// and six for lane products, level, square, rounding, 4*pi and saturation.
// busy is high only during reset; reset clears the valid pipeline and cfg.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none
module gyroid_potential_gradient (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic [gpg_pkg::COORD_BITS-1:0]          in_coord_x,
  input  wire logic [gpg_pkg::COORD_BITS-1:0]          in_coord_y,
  input  wire logic [gpg_pkg::COORD_BITS-1:0]          in_coord_z,
  input  wire logic                                   cfg_we,
  input  wire logic signed [15:0]                     cfg_wdata,
  output logic                                        out_valid,
  output logic [gpg_pkg::PEN_W-1:0]                    out_penalty,
  output logic signed [gpg_pkg::GRAD_W-1:0]            out_grad_x,
  output logic signed [gpg_pkg::GRAD_W-1:0]            out_grad_y,
  output logic signed [gpg_pkg::GRAD_W-1:0]            out_grad_z
);
  localparam int CB = gpg_pkg::COORD_BITS;
  localparam int SH_DN = (CB >= 16) ? CB - 16 : 0;
  localparam int SH_UP = (CB < 16) ? 16 - CB : 0;
  localparam int NL = gpg_pkg::LANES;

  logic [gpg_pkg::LATENCY-1:0] vld_r, vld_nxt;
  logic signed [15:0] offset_r, offset_nxt;

  logic [14:0] u1_r [NL], u2_r [NL], u3_r [NL], u4_r [NL], u5_r [NL], u6_r [NL];
  logic        ng1_r [NL], ng2_r [NL], ng3_r [NL], ng4_r [NL], ng5_r [NL], ng6_r [NL];
  logic signed [31:0] t2_r [NL], t3_r [NL], t4_r [NL], t5_r [NL];
  logic signed [31:0] p3_r [NL], p4_r [NL], p5_r [NL], p6_r [NL];
  logic signed [15:0] s7_r [NL];
  logic signed [31:0] m8_r [9];
  logic signed [31:0] v9_r, tm9_r [3];
  logic signed [63:0] vv10_r, vt10_r [3];
  logic [gpg_pkg::PEN_W-1:0] pen11_r, pen12_r;
  logic signed [39:0] pr11_r [3];
  logic signed [63:0] g12_r [3];
  logic [gpg_pkg::PEN_W-1:0] pen_r;
  logic signed [gpg_pkg::GRAD_W-1:0] gr_r [3];

  logic [15:0] ph [3];
  logic [15:0] lph [NL];

  assign busy = ~rst_n;

  always_comb begin
    vld_nxt = {vld_r[gpg_pkg::LATENCY-2:0], start & rst_n};
    offset_nxt = cfg_we ? cfg_wdata : offset_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      offset_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      offset_r <= offset_nxt;
    end
  end

  // coordinate to 16-bit phase, then sine and cosine phases per lane
  always_comb begin
    ph[0] = (CB >= 16) ? 16'(in_coord_x >> SH_DN) : 16'(16'(in_coord_x) << SH_UP);
    ph[1] = (CB >= 16) ? 16'(in_coord_y >> SH_DN) : 16'(16'(in_coord_y) << SH_UP);
    ph[2] = (CB >= 16) ? 16'(in_coord_z >> SH_DN) : 16'(16'(in_coord_z) << SH_UP);
    for (int i = 0; i < 3; i++) begin
      lph[i] = ph[i];
      lph[i+3] = ph[i] + 16'd16384;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NL; i++) begin
      // stage 1: quadrant fold
      u1_r[i] <= lph[i][14] ? (gpg_pkg::ONE_Q14 - {1'b0, lph[i][13:0]})
                            : {1'b0, lph[i][13:0]};
      ng1_r[i] <= lph[i][15];
      // stage 2: t^2 in Q30 is u*u*4
      t2_r[i] <= 32'({30'(u1_r[i]) * 30'(u1_r[i]), 2'b00});
      u2_r[i] <= u1_r[i];
      ng2_r[i] <= ng1_r[i];
      // stages 3..6: Horner
      p3_r[i] <= gpg_pkg::A7 + 32'((64'(gpg_pkg::A9) * 64'(t2_r[i])) >>> 30);
      t3_r[i] <= t2_r[i]; u3_r[i] <= u2_r[i]; ng3_r[i] <= ng2_r[i];
      p4_r[i] <= gpg_pkg::A5 + 32'((64'(p3_r[i]) * 64'(t3_r[i])) >>> 30);
      t4_r[i] <= t3_r[i]; u4_r[i] <= u3_r[i]; ng4_r[i] <= ng3_r[i];
      p5_r[i] <= gpg_pkg::A3 + 32'((64'(p4_r[i]) * 64'(t4_r[i])) >>> 30);
      t5_r[i] <= t4_r[i]; u5_r[i] <= u4_r[i]; ng5_r[i] <= ng4_r[i];
      p6_r[i] <= gpg_pkg::A1 + 32'((64'(p5_r[i]) * 64'(t5_r[i])) >>> 30);
      u6_r[i] <= u5_r[i]; ng6_r[i] <= ng5_r[i];
    end
  end

  // stage 7: final multiply, round to Q14, clamp, sign
  always_ff @(posedge clk) begin
    for (int i = 0; i < NL; i++) begin
      logic signed [63:0] y;
      logic signed [63:0] s;
      logic signed [15:0] m;
      y = (64'(p6_r[i]) * $signed({49'd0, u6_r[i]})) >>> 14;
      s = (y + 64'sd32768) >>> 16;
      if (s < 0) m = '0;
      else if (s > 64'sd16384) m = 16'sd16384;
      else m = 16'(s);
      s7_r[i] <= ng6_r[i] ? -m : m;
    end
  end

  // stage 8: lane products; lanes 0..2 sine x,y,z, 3..5 cosine x,y,z
  always_ff @(posedge clk) begin
    m8_r[0] <= 32'(s7_r[3]) * 32'(s7_r[2]);  // cx*sz
    m8_r[1] <= 32'(s7_r[5]) * 32'(s7_r[1]);  // cz*sy
    m8_r[2] <= 32'(s7_r[4]) * 32'(s7_r[0]);  // cy*sx
    m8_r[3] <= 32'(s7_r[4]) * 32'(s7_r[3]);  // cy*cx
    m8_r[4] <= 32'(s7_r[0]) * 32'(s7_r[2]);  // sx*sz
    m8_r[5] <= 32'(s7_r[5]) * 32'(s7_r[4]);  // cz*cy
    m8_r[6] <= 32'(s7_r[1]) * 32'(s7_r[0]);  // sy*sx
    m8_r[7] <= 32'(s7_r[5]) * 32'(s7_r[3]);  // cz*cx
    m8_r[8] <= 32'(s7_r[2]) * 32'(s7_r[1]);  // sz*sy
  end

  // stage 9: level and partial terms
  always_ff @(posedge clk) begin
    v9_r <= m8_r[0] + m8_r[1] + m8_r[2] - 32'({{2{offset_r[15]}}, offset_r, 14'd0});
    tm9_r[0] <= m8_r[3] - m8_r[4];
    tm9_r[1] <= m8_r[5] - m8_r[6];
    tm9_r[2] <= m8_r[7] - m8_r[8];
  end

  // stage 10: square and level times terms
  always_ff @(posedge clk) begin
    vv10_r <= 64'(v9_r) * 64'(v9_r);
    for (int i = 0; i < 3; i++) vt10_r[i] <= 64'(v9_r) * 64'(tm9_r[i]);
  end

  // stage 11: penalty rounding, Q28 product rounding
  always_ff @(posedge clk) begin
    logic [63:0] pq;
    pq = (64'(vv10_r) + (64'd1 << 41)) >> 42;
    pen11_r <= (pq > 64'd524287) ? {gpg_pkg::PEN_W{1'b1}} : gpg_pkg::PEN_W'(pq);
    for (int i = 0; i < 3; i++) pr11_r[i] <= 40'((vt10_r[i] + (64'sd1 <<< 27)) >>> 28);
  end

  // stage 12: times 4*pi
  always_ff @(posedge clk) begin
    pen12_r <= pen11_r;
    for (int i = 0; i < 3; i++) g12_r[i] <= 64'(pr11_r[i]) * 64'(gpg_pkg::FOUR_PI_Q24);
  end

  // stage 13: round to Q14 and saturate
  always_ff @(posedge clk) begin
    pen_r <= pen12_r;
    for (int i = 0; i < 3; i++) begin
      logic signed [63:0] g;
      g = (g12_r[i] + (64'sd1 <<< 37)) >>> 38;
      if (g > 64'sd2097151) gr_r[i] <= 22'sd2097151;
      else if (g < -64'sd2097152) gr_r[i] <= -22'sd2097152;
      else gr_r[i] <= gpg_pkg::GRAD_W'(g);
    end
  end

  assign out_valid = vld_r[gpg_pkg::LATENCY-1];
  assign out_penalty = pen_r;
  assign out_grad_x = gr_r[0];
  assign out_grad_y = gr_r[1];
  assign out_grad_z = gr_r[2];
endmodule
`default_nettype wire

// ===== rtl/core/gpg_checker.sv =====
// Port-level checks on the gyroid pipeline, bound to gyroid_potential_gradient.
`default_nettype none
module gpg_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire logic [gpg_pkg::PEN_W-1:0] out_penalty
);
  localparam int LAT = gpg_pkg::LATENCY;

  a_busy: assert property (@(posedge clk) rst_n |-> !busy)
    else $error("busy high out of reset");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe after reset");
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("accepted point gave no result");
  a_nox: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !$isunknown(out_penalty))
    else $error("unknown penalty on strobe");
endmodule

bind gyroid_potential_gradient gpg_checker u_gpg_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_penalty(out_penalty)
);
`default_nettype wire
